[rtl/crq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crq_pkg: shared types and constants of the cycle-tagged ring queue
// Request and response payloads, status codes and controller commands.
// ----------------------------------------------------------------------------
package crq_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W          = 64;
   localparam int COUNT_W          = 64;

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_MARKER = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic               mode;
      logic [VALUE_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] out_value;
      logic               now_empty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic rd_head;
      logic eval;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

`default_nettype wire

[rtl/cycle_tagged_ring_queue_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cycle_tagged_ring_queue_top: cycle-tagged ring queue
// Each request either enqueues a value or dequeues one; every request
// gets exactly one response with status, value and an empty flag.
//
// Request channel req_*: valid/stall, payload mode and item_value.
// Response channel rsp_*: valid/stall, payload status, out_value, now_empty.
// csr_wr_en/csr_wr_data write the empty marker; write only while idle.
// Steps per request: take, slot RAM read, evaluate, load the response
// register; the load waits in the final step while the output register
// is still full and stalled. The sequencer handles one request at a time,
// and its slot RAM read is registered.
// The next request is taken while a response still waits in the output
// register; if the receiver stalls, the following result holds in the
// sequencer and req_stall stays high until the register frees up.
// Reset: counters return to the ring size, the marker to all ones, and a
// clearing pass over every ring slot zeroes the tags, with req_stall high
// throughout.
// ----------------------------------------------------------------------------
module cycle_tagged_ring_queue_top #(
   parameter int CAPACITY = crq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire crq_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output crq_pkg::rsp_type                 rsp_payload,
   input  wire logic                        csr_wr_en,
   input  wire logic [crq_pkg::VALUE_W-1:0] csr_wr_data
);

   crq_pkg::cmd_type  cmd;
   crq_pkg::stat_type stat;

   crq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   crq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

`default_nettype wire

[rtl/crq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crq_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module crq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/crq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crq_datapath: counters, slot RAM and result registers
// Holds head and tail counters (count, slot index and cycle tag), the
// marker register, the tag/value RAM and the response register.
// ----------------------------------------------------------------------------
module crq_datapath #(
   parameter int CAPACITY = crq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire crq_pkg::cmd_type  cmd,
   output crq_pkg::stat_type      stat,
   input  wire crq_pkg::req_type  req_payload,
   output crq_pkg::rsp_type       rsp_payload,
   input  wire logic              csr_wr_en,
   input  wire logic [crq_pkg::VALUE_W-1:0] csr_wr_data
);

   localparam int RING    = ((CAPACITY + 3) / 4) * 4;
   localparam int QUARTER = RING / 4;
   localparam int AW      = $clog2(RING);
   localparam int TW      = 65 - $clog2(RING + 1);
   localparam int VW      = crq_pkg::VALUE_W;
   localparam int CW      = crq_pkg::COUNT_W;

   typedef struct packed {
      logic [CW-1:0] cnt;
      logic [AW-1:0] idx;
      logic [TW-1:0] cyc;
   } ctr_type;

   localparam ctr_type CTR_RESET = '{cnt: CW'(RING), idx: '0, cyc: TW'(1)};

   function automatic ctr_type ctr_next(input ctr_type c);
      ctr_type n;
      n = c;
      if (c.cnt == {CW{1'b1}}) begin
         n = '{cnt: '0, idx: '0, cyc: '0};
      end else begin
         n.cnt = c.cnt + CW'(1);
         if (c.idx == AW'(RING - 1)) begin
            n.idx = '0;
            n.cyc = c.cyc + TW'(1);
         end else begin
            n.idx = c.idx + AW'(1);
         end
      end
      return n;
   endfunction

   // spread consecutive positions over the four groups
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] idx);
      logic [AW-1:0] base;
      base = '0;
      case (idx[1:0])
         2'd0:    base = '0;
         2'd1:    base = AW'(QUARTER);
         2'd2:    base = AW'(2 * QUARTER);
         default: base = AW'(3 * QUARTER);
      endcase
      return base + (idx >> 2);
   endfunction

   ctr_type head_ff, head_in, tail_ff, tail_in;
   logic [VW-1:0] empty_code_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          req_mode_ff;
   logic [VW-1:0] req_value_ff;
   crq_pkg::status_type res_status_ff, res_status_in;
   logic [VW-1:0] res_value_ff, res_value_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [TW+VW-1:0] ram_wr_data, ram_rd_data;
   logic [TW-1:0] rd_tag;
   logic [VW-1:0] rd_value;
   logic          is_marker, is_full, tag_hit, enq_ok;

   assign rd_tag   = ram_rd_data[TW+VW-1:VW];
   assign rd_value = ram_rd_data[VW-1:0];

   assign is_marker = req_value_ff == empty_code_ff;
   assign is_full   = (tail_ff.cnt - head_ff.cnt) >= CW'(RING);
   assign tag_hit   = rd_tag == head_ff.cyc;
   assign enq_ok    = cmd.eval && req_mode_ff == crq_pkg::MODE_ENQ && !is_marker && !is_full;

   assign stat.clear_last = clr_addr_ff == AW'(RING - 1);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      if (cmd.eval) begin
         res_value_in = empty_code_ff;
         if (req_mode_ff == crq_pkg::MODE_ENQ) begin
            if (is_marker) begin
               res_status_in = crq_pkg::STATUS_MARKER;
            end else if (is_full) begin
               res_status_in = crq_pkg::STATUS_FULL;
            end else begin
               res_status_in = crq_pkg::STATUS_DONE;
               tail_in       = ctr_next(tail_ff);
            end
         end else begin
            if (tag_hit) begin
               res_status_in = crq_pkg::STATUS_DONE;
               res_value_in  = rd_value;
               head_in       = ctr_next(head_ff);
            end else begin
               res_status_in = crq_pkg::STATUS_EMPTY;
            end
         end
      end
   end

   assign ram_wr_en   = cmd.clear_step || enq_ok;
   assign ram_wr_addr = cmd.clear_step ? clr_addr_ff : slot_of(tail_ff.idx);
   assign ram_wr_data = cmd.clear_step ? '0 : {tail_ff.cyc, req_value_ff};

   crq_ram #(
      .WIDTH (TW + VW),
      .DEPTH (RING)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_head),
      .rd_addr (slot_of(head_ff.idx)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= CTR_RESET;
         tail_ff       <= CTR_RESET;
         empty_code_ff <= {VW{1'b1}};
         clr_addr_ff   <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (csr_wr_en) begin
            empty_code_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_mode_ff  <= req_payload.mode;
         req_value_ff <= req_payload.item_value;
      end
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      if (cmd.load_rsp) begin
         rsp_payload.status    <= res_status_ff;
         rsp_payload.out_value <= res_value_ff;
         rsp_payload.now_empty <= head_ff.cnt >= tail_ff.cnt;
      end
   end

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      (tail_ff.cnt - head_ff.cnt) <= CW'(RING))
      else $error("queue occupancy beyond ring size");

   a_head_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.eval && req_mode_ff == crq_pkg::MODE_DEQ && tag_hit
      |=> head_ff.cnt == $past(head_ff.cnt) + CW'(1))
      else $error("head did not advance on dequeue");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      !enq_ok |=> tail_ff.cnt == $past(tail_ff.cnt))
      else $error("tail moved without a stored enqueue");

endmodule

`default_nettype wire

[rtl/crq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crq_ctrl: request sequencer of the cycle-tagged ring queue
// Runs the clearing pass after reset, then steps each request through
// slot read, evaluation and response load, and owns the response valid.
// ----------------------------------------------------------------------------
module crq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output crq_pkg::cmd_type       cmd,
   input  wire crq_pkg::stat_type stat
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_FINAL = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            // hold until the response register frees up
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 state_ff == ST_EVAL)
      else $error("accepted request did not reach evaluation");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINAL))
      else $error("response raised outside final step");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |=> !rsp_valid_ff)
      else $error("response during clearing pass");

endmodule

`default_nettype wire
